// File: rtl/mcl_pkg.sv
// Shared constants, types and elaboration-time tables for the lattice update block.
// Depends on nothing; every other file imports it.
`default_nettype none

package mcl_pkg;

	// lattice geometry
	localparam int SIDE    = 10;
	localparam int CELLS   = SIDE * SIDE;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int M_W     = $clog2(SIDE);
	localparam int COORD_W = 4;

	// payload and register widths
	localparam int RAND_BITS = 16;
	localparam int SPIN_W    = 2;
	localparam int E_W       = 20;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PAIR = 1'b0;

	// two-link count bounds: one unit per ordered triple of distinct indices
	localparam int H4_MAX = SIDE * (SIDE - 1) * (SIDE - 2);
	localparam int H4_W   = $clog2(H4_MAX + 1) + 1;
	localparam int DSUM_W = $clog2(10 * (SIDE - 2) + 1) + 1;
	localparam int H4X_W  = ((H4_W > DSUM_W) ? H4_W : DSUM_W) + 1;

	// Q31 arithmetic for the acceptance threshold
	localparam int MUL_W  = 32;
	localparam int Q_FRAC = 31;
	localparam logic [MUL_W-1:0] QONE = MUL_W'(64'd1 << Q_FRAC);
	localparam int D_BITS = E_W;
	localparam int K_W    = $clog2(D_BITS);

	// exp(-1/SIDE^2) in Q31 by the alternating series, each term floored;
	// the eighth term is already zero for any lattice of side three or more
	localparam logic [63:0] EXP_T0   = 64'd1 << Q_FRAC;
	localparam logic [63:0] EXP_T1   = EXP_T0 / 64'(CELLS);
	localparam logic [63:0] EXP_T2   = EXP_T1 / (64'(CELLS) * 64'd2);
	localparam logic [63:0] EXP_T3   = EXP_T2 / (64'(CELLS) * 64'd3);
	localparam logic [63:0] EXP_T4   = EXP_T3 / (64'(CELLS) * 64'd4);
	localparam logic [63:0] EXP_T5   = EXP_T4 / (64'(CELLS) * 64'd5);
	localparam logic [63:0] EXP_T6   = EXP_T5 / (64'(CELLS) * 64'd6);
	localparam logic [63:0] EXP_T7   = EXP_T6 / (64'(CELLS) * 64'd7);
	localparam logic [63:0] EXP_BASE = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3
		+ EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7;

	typedef logic signed [SPIN_W-1:0] spin_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		spin_t             data;
	} ram_wr_t;

	typedef enum logic {
		MUL_ENERGY,
		MUL_EXP
	} mul_op_t;

	typedef struct packed {
		mul_op_t          op;
		logic [CFG_W-1:0] weight;
		logic [H4_W-1:0]  count;
		logic [MUL_W-1:0] base;
		logic [MUL_W-1:0] pow;
	} mul_req_t;

	typedef logic [MUL_W-1:0] pow_tab_t [D_BITS];

	// successive squares of the base, one per bit of the energy step
	function automatic pow_tab_t build_pow_tab();
		pow_tab_t    tab;
		logic [63:0] p;
		p = EXP_BASE;
		for (int k = 0; k < D_BITS; k++) begin
			tab[k] = p[MUL_W-1:0];
			p = (p * p) >> Q_FRAC;
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col);
		logic [ADDR_W-1:0] r_w;
		r_w = ADDR_W'(row);
		return ADDR_W'(r_w * ADDR_W'(SIDE)) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// File: rtl/mcl_spin_ram.sv
// Spin store: one write port, two registered read ports, per-entry valid bits.
// Depends on mcl_pkg for geometry and the write word type.
`default_nettype none

module mcl_spin_ram import mcl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ram_wr_t           wr,
	input  wire logic              clear,
	input  wire logic [ADDR_W-1:0] addr_a,
	input  wire logic [ADDR_W-1:0] addr_b,
	output spin_t                  data_a,
	output spin_t                  data_b
);

	spin_t            spin_mem_q [CELLS];
	logic [CELLS-1:0] valid_q;
	spin_t            rd_a_q;
	spin_t            rd_b_q;
	logic             rv_a_q;
	logic             rv_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			spin_mem_q[wr.addr] <= wr.data;
		end
		rd_a_q <= spin_mem_q[addr_a];
		rd_b_q <= spin_mem_q[addr_b];
	end

	// an entry never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_a_q  <= 1'b0;
			rv_b_q  <= 1'b0;
		end else begin
			rv_a_q <= valid_q[addr_a];
			rv_b_q <= valid_q[addr_b];
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign data_a = rv_a_q ? rd_a_q : spin_t'(0);
	assign data_b = rv_b_q ? rd_b_q : spin_t'(0);

endmodule

`default_nettype wire

// File: rtl/mcl_mul.sv
// Shared multiplier: energy weighting and Q31 threshold products.
// Depends on mcl_pkg for the request word.
`default_nettype none

module mcl_mul import mcl_pkg::*; (
	input  wire mul_req_t         req,
	output logic [MUL_W-1:0]      res
);

	logic [MUL_W-1:0]   x;
	logic [MUL_W-1:0]   y;
	logic [2*MUL_W-1:0] prod;

	always_comb begin
		case (req.op)
			MUL_ENERGY: begin
				x = MUL_W'(req.weight);
				y = MUL_W'(req.count);
			end
			MUL_EXP: begin
				x = req.base;
				y = req.pow;
			end
			default: begin
				x = '0;
				y = '0;
			end
		endcase
		prod = (2*MUL_W)'(x) * (2*MUL_W)'(y);
		// Q31 product drops the fraction; energy product is plain integer
		if (req.op == MUL_EXP) begin
			res = prod[Q_FRAC+MUL_W-1:Q_FRAC];
		end else begin
			res = prod[MUL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/metropolis_causal_lattice_update.sv
// Top level: sequencer of the Metropolis lattice update around the spin store
// and the shared multiplier. Depends on mcl_pkg, mcl_spin_ram and mcl_mul.
//
// Usage. Input words arrive on in_valid/in_ready: req_type picks a proposal at
// (site_row, site_col) or a lattice clear. Each word gives one result word on
// out_valid/out_ready: the spin left at the site, whether the change was kept,
// and the stored energy (times SIDE squared) after the word.
// Timing. One word at a time; in_ready is high only while the sequencer idles.
// A clear, a diagonal site or a site off the lattice goes from idle straight to
// the finishing state. A proposal reads its own spin, then scans the third
// index, one site pair per cycle through the two read ports of the spin store,
// forms the new energy on the shared multiplier and compares. When the energy
// rises, the threshold is built by the same multiplier, one bit of the energy
// step per cycle; a rejected word skips the two store writes. Reset clears the
// lattice (per-entry valid bits, no sweep) and the energy, and sets the pair
// weight to 1. A stalled receiver holds the result word; the next input word
// is taken meanwhile and waits only to deliver its own result. Weights are to
// be written on cfg_wen/cfg_index/cfg_data only while idle; the block itself
// does not enforce this. The three-link weight is taken but has no effect:
// with s(j,i) = -s(i,j) the six terms that share any site pair cancel, so the
// three-link sum stays zero.
`default_nettype none

module metropolis_causal_lattice_update import mcl_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	// input channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    req_type,
	input  wire logic [COORD_W-1:0]      site_row,
	input  wire logic [COORD_W-1:0]      site_col,
	input  wire logic                    step_choice,
	input  wire logic [RAND_BITS-1:0]    accept_random,
	// output channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [SPIN_W-1:0]     new_spin,
	output logic                         accepted,
	output logic signed [E_W-1:0]        energy_scaled
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READV,
		ST_SCAN,
		ST_SUM,
		ST_MULE,
		ST_DIFF,
		ST_EXP,
		ST_CMP,
		ST_WR1,
		ST_WR2,
		ST_FINISH
	} state_t;

	localparam int DIF_W = E_W + 1;

	state_t                     state_q;
	logic [CFG_W-1:0]           alpha_q;
	logic signed [E_W-1:0]      energy_q;
	logic signed [H4_W-1:0]     h4_q;
	logic signed [H4_W-1:0]     h4n_q;
	logic signed [DSUM_W-1:0]   sum_q;
	logic signed [E_W-1:0]      e_new_q;
	logic [COORD_W-1:0]         a_q;
	logic [COORD_W-1:0]         b_q;
	logic                       step_q;
	logic [RAND_BITS-1:0]       rnd_q;
	logic [M_W-1:0]             m_q;
	spin_t                      v_q;
	spin_t                      vn_q;
	logic [D_BITS-1:0]          d_q;
	logic [K_W-1:0]             k_q;
	logic [MUL_W-1:0]           r_q;
	spin_t                      res_spin_q;
	logic                       res_acc_q;
	logic                       out_valid_q;
	spin_t                      out_spin_q;
	logic                       out_acc_q;
	logic signed [E_W-1:0]      out_energy_q;

	ram_wr_t                    ram_wr;
	logic                       ram_clear;
	logic [ADDR_W-1:0]          addr_a;
	logic [ADDR_W-1:0]          addr_b;
	spin_t                      data_a;
	spin_t                      data_b;
	mul_req_t                   mul_req;
	logic [MUL_W-1:0]           mul_res;

	logic                       in_take;
	logic                       in_range;
	logic [M_W-1:0]             m_next;
	logic signed [H4X_W-1:0]    h4_sum;
	logic [H4_W-1:0]            h4_mag;
	logic signed [E_W-1:0]      e_mag;
	logic signed [DIF_W-1:0]    diff;
	logic [2*MUL_W-1:0]         thr_wide;
	logic [RAND_BITS:0]         thr;
	logic                       keep;

	// spin advanced by one or two with wrap inside {-1, 0, 1}
	function automatic spin_t spin_step(input spin_t old, input logic two);
		spin_t nv;
		case ({old, two})
			{2'sb11, 1'b0}: nv = 2'sb00;
			{2'sb00, 1'b0}: nv = 2'sb01;
			{2'sb01, 1'b0}: nv = 2'sb11;
			{2'sb11, 1'b1}: nv = 2'sb01;
			{2'sb00, 1'b1}: nv = 2'sb11;
			{2'sb01, 1'b1}: nv = 2'sb00;
			default:        nv = 2'sb00;
		endcase
		return nv;
	endfunction

	// change of the two-link count from the six terms that share the pair
	// (a,b) and third index m; g = s(a,m), h = s(b,m)
	function automatic logic signed [4:0] link_delta(input spin_t g, input spin_t h,
		input spin_t v, input spin_t vn);
		logic signed [4:0] g5;
		logic signed [4:0] h5;
		logic signed [4:0] v5;
		logic signed [4:0] n5;
		logic signed [4:0] gh;
		logic signed [4:0] t;
		g5 = 5'(g);
		h5 = 5'(h);
		v5 = 5'(v);
		n5 = 5'(vn);
		gh = g5 * h5;
		t  = (n5 - v5) * (h5 - g5) + (n5 * n5 - v5 * v5);
		return 5'sd2 * gh * t;
	endfunction

	mcl_spin_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ram_wr),
		.clear  (ram_clear),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.data_a (data_a),
		.data_b (data_b)
	);

	mcl_mul u_mul (
		.req (mul_req),
		.res (mul_res)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign in_range = ({1'b0, site_row} < (COORD_W+1)'(SIDE))
		&& ({1'b0, site_col} < (COORD_W+1)'(SIDE));
	assign m_next   = (m_q == M_W'(SIDE - 1)) ? '0 : m_q + 1'b1;

	assign h4_sum   = H4X_W'(h4_q) + H4X_W'(sum_q);
	assign h4_mag   = h4n_q[H4_W-1] ? H4_W'(-h4n_q) : H4_W'(h4n_q);
	assign e_mag    = E_W'(mul_res);
	assign diff     = DIF_W'(e_new_q) - DIF_W'(energy_q);
	assign thr_wide = (2*MUL_W)'(r_q) << RAND_BITS;
	assign thr      = thr_wide[RAND_BITS+Q_FRAC:Q_FRAC];
	assign keep     = ({1'b0, rnd_q} <= thr);

	// store addressing, write words and multiplier operands
	always_comb begin
		addr_a      = '0;
		addr_b      = '0;
		ram_wr      = '0;
		ram_clear   = 1'b0;
		mul_req     = '0;
		mul_req.op  = MUL_ENERGY;
		case (state_q)
			ST_IDLE: begin
				if (in_range) begin
					addr_a = cell_addr(site_row, site_col);
				end
				ram_clear = in_take && req_type;
			end
			ST_READV: begin
				addr_a = cell_addr(a_q, '0);
				addr_b = cell_addr(b_q, '0);
			end
			ST_SCAN: begin
				addr_a = cell_addr(a_q, COORD_W'(m_next));
				addr_b = cell_addr(b_q, COORD_W'(m_next));
			end
			ST_MULE: begin
				mul_req.op     = MUL_ENERGY;
				mul_req.weight = alpha_q;
				mul_req.count  = h4_mag;
			end
			ST_EXP: begin
				mul_req.op   = MUL_EXP;
				mul_req.base = r_q;
				mul_req.pow  = POW_TAB[k_q];
			end
			ST_WR1: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cell_addr(a_q, b_q);
				ram_wr.data = vn_q;
			end
			ST_WR2: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cell_addr(b_q, a_q);
				ram_wr.data = -vn_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alpha_q     <= CFG_W'(1);
			energy_q    <= '0;
			h4_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen && (cfg_index == REG_PAIR)) begin
				alpha_q <= cfg_data;
			end

			// drop the result word once the receiver takes it, unless the
			// finishing word replaces it in the same cycle
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						a_q        <= site_row;
						b_q        <= site_col;
						step_q     <= step_choice;
						rnd_q      <= accept_random;
						res_spin_q <= '0;
						res_acc_q  <= 1'b0;
						if (req_type) begin
							energy_q <= '0;
							h4_q     <= '0;
							state_q  <= ST_FINISH;
						end else if (!in_range || (site_row == site_col)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_READV;
						end
					end
				end
				ST_READV: begin
					v_q     <= data_a;
					vn_q    <= spin_step(data_a, step_q);
					m_q     <= '0;
					sum_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if ((COORD_W'(m_q) != a_q) && (COORD_W'(m_q) != b_q)) begin
						sum_q <= sum_q + DSUM_W'(link_delta(data_a, data_b, v_q, vn_q));
					end
					m_q <= m_next;
					if (m_q == M_W'(SIDE - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					h4n_q   <= H4_W'(h4_sum);
					state_q <= ST_MULE;
				end
				ST_MULE: begin
					// energy is minus the weighted two-link count
					e_new_q <= h4n_q[H4_W-1] ? e_mag : -e_mag;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (diff <= 0) begin
						res_spin_q <= vn_q;
						res_acc_q  <= 1'b1;
						state_q    <= ST_WR1;
					end else begin
						d_q     <= D_BITS'(diff);
						k_q     <= '0;
						r_q     <= QONE;
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					// advance one bit of the energy step per cycle
					if (d_q == '0) begin
						state_q <= ST_CMP;
					end else begin
						if (d_q[0]) begin
							r_q <= mul_res;
						end
						d_q <= d_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
				ST_CMP: begin
					if (keep) begin
						res_spin_q <= vn_q;
						res_acc_q  <= 1'b1;
						state_q    <= ST_WR1;
					end else begin
						res_spin_q <= v_q;
						res_acc_q  <= 1'b0;
						state_q    <= ST_FINISH;
					end
				end
				ST_WR1: begin
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					energy_q <= e_new_q;
					h4_q     <= h4n_q;
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold here while the previous result word is still waiting
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_spin_q   <= res_spin_q;
						out_acc_q    <= res_acc_q;
						out_energy_q <= energy_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign new_spin      = out_spin_q;
	assign accepted      = out_acc_q;
	assign energy_scaled = out_energy_q;

endmodule

`default_nettype wire

// File: tb/tb_metropolis_causal_lattice_update.sv
// Self-checking bench for metropolis_causal_lattice_update: a directed table, then
// random phases under several coupling weights, checked against an in-bench model.
// Depends on mcl_pkg and the block's RTL.

module tb_metropolis_causal_lattice_update import mcl_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// request kinds and step sizes of an input word
	localparam logic REQ_PROPOSE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;
	localparam logic STEP_ONE    = 1'b0;
	localparam logic STEP_TWO    = 1'b1;

	// the package names the pair weight only; the triple weight sits next to it
	localparam logic [CFG_IDX_W-1:0] REG_TRIPLE = 1'b1;

	localparam longint unsigned Q31_ONE = 64'd1 << 31;
	localparam int COORD_MAX     = (1 << COORD_W) - 1;
	localparam int PLAN_LEN      = 22;
	localparam int PHASES        = 7;
	localparam int PHASE_MOVES   = 170;
	localparam int LONG_HOLD     = 250;
	// worst proposal: read, third-index scan, energy, then the threshold bit by bit
	localparam int DRAIN_CYCLES  = SIDE + D_BITS + 12;

	typedef struct packed {
		logic                 req;
		logic [COORD_W-1:0]   row;
		logic [COORD_W-1:0]   col;
		logic                 step;
		logic [RAND_BITS-1:0] rnd;
	} move_word_t;

	typedef struct packed {
		spin_t                spin;
		logic                 acc;
		logic signed [E_W-1:0] energy;
	} move_result_t;

	typedef struct packed {
		move_word_t   w;
		logic         typed;
		move_result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [COORD_W-1:0] site_row;
	logic [COORD_W-1:0] site_col;
	logic step_choice;
	logic [RAND_BITS-1:0] accept_random;
	logic out_valid;
	logic out_ready;
	logic signed [SPIN_W-1:0] new_spin;
	logic accepted;
	logic signed [E_W-1:0] energy_scaled;

	// bench-side copy of the lattice, stored energy and weights
	spin_t lattice [SIDE][SIDE];
	int energy_q;
	logic [CFG_W-1:0] weight_pair;
	logic [CFG_W-1:0] weight_triple;

	move_result_t pending_results [$];
	int mismatches;
	bit quiet_src;
	bit quiet_sink;
	bit hold_sink;

	// Directed words, all under the reset weights. A typed row carries its result
	// by hand: reset state, the diagonal, off-lattice sites, clears, lone spins.
	plan_row_t stim_plan [PLAN_LEN] = '{
		'{'{REQ_PROPOSE, 4'd0,  4'd0,  STEP_ONE, 16'h0000}, 1'b1, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd15, 4'd15, STEP_TWO, 16'hFFFF}, 1'b1, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd10, 4'd2,  STEP_ONE, 16'h0000}, 1'b1, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd3,  4'd12, STEP_TWO, 16'h5555}, 1'b1, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd0,  4'd1,  STEP_ONE, 16'hFFFF}, 1'b1, '{2'sd1, 1'b1, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd0,  4'd1,  STEP_TWO, 16'hAAAA}, 1'b1, '{2'sd0, 1'b1, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd0,  4'd1,  STEP_TWO, 16'h0000}, 1'b1, '{-2'sd1, 1'b1, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd1,  4'd2,  STEP_ONE, 16'h0000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd2,  4'd0,  STEP_ONE, 16'hFFFF}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd5,  4'd7,  STEP_TWO, 16'h0000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd7,  4'd5,  STEP_ONE, 16'h8000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd9,  4'd8,  STEP_ONE, 16'hFFFF}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd8,  4'd9,  STEP_TWO, 16'h0000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd9,  4'd9,  STEP_TWO, 16'hFFFF}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd3,  4'd4,  STEP_ONE, 16'h0000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd4,  4'd3,  STEP_ONE, 16'h0000}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd6,  4'd1,  STEP_TWO, 16'h0001}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd1,  4'd6,  STEP_ONE, 16'hFFFF}, 1'b0, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_CLEAR,   4'd15, 4'd15, STEP_TWO, 16'hFFFF}, 1'b1, '{2'sd0, 1'b0, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd9,  4'd0,  STEP_ONE, 16'h0000}, 1'b1, '{2'sd1, 1'b1, 20'sd0}},
		'{'{REQ_PROPOSE, 4'd0,  4'd9,  STEP_ONE, 16'h1234}, 1'b1, '{2'sd0, 1'b1, 20'sd0}},
		'{'{REQ_CLEAR,   4'd0,  4'd0,  STEP_ONE, 16'h0000}, 1'b1, '{2'sd0, 1'b0, 20'sd0}}
	};

	metropolis_causal_lattice_update uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.site_row      (site_row),
		.site_col      (site_col),
		.step_choice   (step_choice),
		.accept_random (accept_random),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_spin      (new_spin),
		.accepted      (accepted),
		.energy_scaled (energy_scaled)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Scaled energy of the whole lattice: -(beta*H3 + alpha*H4) over all ordered
	// triples of distinct indices whose (k,i) link is set.
	function automatic int lattice_energy();
		int h3;
		int h4;
		int prod;
		h3 = 0;
		h4 = 0;
		for (int i = 0; i < SIDE; i++) begin
			for (int j = 0; j < SIDE; j++) begin
				if (i == j)
					continue;
				for (int k = 0; k < SIDE; k++) begin
					if (k == i || k == j || lattice[k][i] == 0)
						continue;
					prod = int'(lattice[i][j]) * int'(lattice[k][j]);
					h3 += prod * int'(lattice[k][i]);
					h4 += prod;
				end
			end
		end
		return -(int'(weight_triple) * h3 + int'(weight_pair) * h4);
	endfunction

	// Acceptance bound for an energy rise: exp(-rise/SIDE^2) in Q31, the base
	// from the floored alternating series, raised by square and multiply from
	// the low bit, then rescaled to RAND_BITS.
	function automatic longint unsigned boltzmann_limit(int unsigned rise);
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned term;
		longint unsigned sq;
		longint unsigned prod;
		pos  = Q31_ONE;
		neg  = 64'd0;
		term = Q31_ONE;
		for (int n = 1; n < 64 && term != 0; n++) begin
			term = term / (64'(SIDE * SIDE) * 64'(n));
			if (n % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		sq   = pos - neg;
		prod = Q31_ONE;
		while (rise != 0) begin
			if (rise[0])
				prod = (prod * sq) >> 31;
			sq = (sq * sq) >> 31;
			rise = rise >> 1;
		end
		return (prod << RAND_BITS) >> 31;
	endfunction

	// Apply one accepted word to the bench lattice and return its result word.
	function automatic move_result_t metropolis_move(move_word_t w);
		move_result_t res;
		int r;
		int c;
		int old_s;
		int next_s;
		int e_new;
		int rise;
		bit keep;
		res.spin = '0;
		res.acc  = 1'b0;
		if (w.req == REQ_CLEAR) begin
			foreach (lattice[i, j])
				lattice[i][j] = '0;
			energy_q = 0;
		end else if (w.row < SIDE && w.col < SIDE) begin
			r = int'(w.row);
			c = int'(w.col);
			if (r == c) begin
				res.spin = lattice[r][c];
			end else begin
				old_s  = int'(lattice[r][c]);
				next_s = old_s + ((w.step == STEP_TWO) ? 2 : 1);
				if (next_s > 1)
					next_s -= 3;
				lattice[r][c] = spin_t'(next_s);
				lattice[c][r] = spin_t'(-next_s);
				e_new = lattice_energy();
				rise  = e_new - energy_q;
				keep  = 1'b1;
				if (rise > 0)
					keep = (64'(w.rnd) <= boltzmann_limit(rise));
				if (keep) begin
					energy_q = e_new;
					res.spin = spin_t'(next_s);
					res.acc  = 1'b1;
				end else begin
					lattice[r][c] = spin_t'(old_s);
					lattice[c][r] = spin_t'(-old_s);
					res.spin = spin_t'(old_s);
				end
			end
		end
		res.energy = E_W'(energy_q);
		return res;
	endfunction

	// Offer one input word after a random gap, hold it until taken, then book
	// its result: the hand-typed one where given, else the bench model's.
	task automatic offer_word(input move_word_t w, input logic typed, input move_result_t typed_res);
		int unsigned gap;
		move_result_t model_res;
		gap = quiet_src ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= w.req;
		site_row      <= w.row;
		site_col      <= w.col;
		step_choice   <= w.step;
		accept_random <= w.rnd;
		do @(posedge clk); while (!in_ready);
		model_res = metropolis_move(w);
		pending_results.push_back(typed ? typed_res : model_res);
	endtask

	// Drop valid, wait for every booked result, then let the block go quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both weights go in on back-to-back cycles, only while the block idles.
	task automatic load_couplings(input logic [CFG_W-1:0] pair_w, input logic [CFG_W-1:0] triple_w);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_PAIR;
		cfg_data  <= pair_w;
		@(posedge clk);
		cfg_index <= REG_TRIPLE;
		cfg_data  <= triple_w;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		weight_pair   = pair_w;
		weight_triple = triple_w;
	endtask

	initial begin : stimulus
		move_word_t w;
		move_result_t none;
		int moves;
		int pick;
		in_valid      <= 1'b0;
		req_type      <= REQ_PROPOSE;
		site_row      <= '0;
		site_col      <= '0;
		step_choice   <= STEP_ONE;
		accept_random <= '0;
		cfg_wen       <= 1'b0;
		cfg_index     <= REG_PAIR;
		cfg_data      <= '0;
		arst_n        <= 1'b0;
		quiet_src     = 1'b0;
		quiet_sink    = 1'b0;
		hold_sink     = 1'b0;
		none          = '0;
		// reset state of the bench model
		foreach (lattice[i, j])
			lattice[i][j] = '0;
		energy_q      = 0;
		weight_pair   = 6'd1;
		weight_triple = 6'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table under the reset weights
		foreach (stim_plan[n])
			offer_word(stim_plan[n].w, stim_plan[n].typed, stim_plan[n].want);
		drain_results();

		// Random phases: each starts idle with fresh weights. Most words are moves
		// on the lattice so that it fills up; off-lattice sites, the diagonal and
		// the rare clear make up the rest and do not count as moves.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       load_couplings(6'd63, 6'd63);
				1:       load_couplings(6'd1, 6'd63);
				2:       load_couplings(6'd63, 6'd0);
				3:       load_couplings(6'd0, 6'd0);
				4:       load_couplings(6'd1, 6'd1);
				default: load_couplings(CFG_W'($urandom_range(0, 63)),
					CFG_W'($urandom_range(0, 63)));
			endcase
			// back-to-back stretches on each side, and on both at once
			quiet_src  = (ph == 1) || (ph == 4);
			quiet_sink = (ph == 2) || (ph == 4);
			moves = 0;
			while (moves < PHASE_MOVES) begin
				// hold the receiver off for a long stretch while words keep coming
				if (ph == 5 && moves == 40)
					hold_sink = 1'b1;
				pick   = $urandom_range(0, 99);
				w.req  = (pick < 2) ? REQ_CLEAR : REQ_PROPOSE;
				w.step = 1'($urandom_range(0, 1));
				if (pick < 2) begin
					w.row = COORD_W'($urandom_range(0, COORD_MAX));
					w.col = COORD_W'($urandom_range(0, COORD_MAX));
				end else if (pick < 10) begin
					if ($urandom_range(0, 1)) begin
						w.row = COORD_W'($urandom_range(SIDE, COORD_MAX));
						w.col = COORD_W'($urandom_range(0, COORD_MAX));
					end else begin
						w.row = COORD_W'($urandom_range(0, COORD_MAX));
						w.col = COORD_W'($urandom_range(SIDE, COORD_MAX));
					end
				end else if (pick < 14) begin
					w.row = COORD_W'($urandom_range(0, SIDE - 1));
					w.col = w.row;
				end else begin
					w.row = COORD_W'($urandom_range(0, SIDE - 1));
					w.col = COORD_W'($urandom_range(0, SIDE - 1));
				end
				case ($urandom_range(0, 7))
					0:       w.rnd = '0;
					1:       w.rnd = '1;
					2, 3:    w.rnd = RAND_BITS'($urandom_range(0, 255));
					default: w.rnd = RAND_BITS'($urandom_range(0, (1 << RAND_BITS) - 1));
				endcase
				offer_word(w, 1'b0, none);
				if (w.req == REQ_PROPOSE && w.row < SIDE && w.col < SIDE && w.row != w.col)
					moves++;
			end
			// pause the sender until every result of the phase is in
			drain_results();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: per result, either take it at once or wait for valid and then
	// hold off for a random stall; on request, hold off for one long stretch.
	initial begin : result_sink
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_sink) begin
				hold_sink = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = quiet_sink ? 0 : $urandom_range(0, 6);
				if (stall != 0) begin
					out_ready <= 1'b0;
					do @(posedge clk); while (!out_valid);
					repeat (stall - 1) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare each taken result word with the oldest booked one, field by field.
	always @(posedge clk) begin : result_check
		move_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result word with none pending: spin %0d accepted %0b energy %0d",
					$time, new_spin, accepted, energy_scaled);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (new_spin !== want.spin) begin
					$display("%0t ns: new_spin expected %0d, got %0d", $time, want.spin, new_spin);
					mismatches++;
				end
				if (accepted !== want.acc) begin
					$display("%0t ns: accepted expected %0b, got %0b", $time, want.acc, accepted);
					mismatches++;
				end
				if (energy_scaled !== want.energy) begin
					$display("%0t ns: energy_scaled expected %0d, got %0d",
						$time, want.energy, energy_scaled);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		mismatches = 0;
		#6ms;
		$display("FAILURE");
		$finish;
	end

endmodule
